// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/pfa_pkg.sv
// ---------------------------------------------------------------------------
// pfa_pkg
// Shared widths, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

   localparam int DEF_MAX_BLOCKS = 16;
   localparam int DEF_SIZE_BITS  = 16;

   localparam int BLOCK_INDEX_W  = 4;
   localparam int REQUEST_SIZE_W = 16;
   localparam int POLICY_W       = 2;
   localparam int COUNT_W        = 5;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 5;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;
   localparam logic [POLICY_W-1:0] POLICY_NEXT  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_POLICY  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_COUNT = 1'd1;

   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic load_start;
      logic req_start;
      logic scan_issue;
      logic commit;
   } pfa_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic issue_last;
      logic out_free;
   } pfa_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/pfa_ram.sv
// ---------------------------------------------------------------------------
// pfa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pfa_ctrl.sv
// ---------------------------------------------------------------------------
// pfa_ctrl
// Sequencer: accept, scan one partition per cycle, drain, commit result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pfa_ctrl
   import pfa_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_op,
   output logic                req_stall,
   input  wire pfa_status_type status,
   output pfa_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_ALLOC) begin
                  cmd.req_start = 1'b1;
                  state_in      = status.count_zero ? ST_COMMIT : ST_SCAN;
               end else begin
                  cmd.load_start = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall = stall_ff;

   `ASSERT_IMPL(a_commit_free, cmd.commit, status.out_free, "commit with result slot busy")
   `ASSERT_NEXT(a_start_stalls, cmd.req_start, req_stall, "request start did not stall input")
   `ASSERT_NEXT(a_scan_order, state_ff == ST_SCAN,
                state_ff == ST_SCAN || state_ff == ST_DRAIN, "scan left out of order")

endmodule

`default_nettype wire

// File: hw/rtl/pfa_dp.sv
// ---------------------------------------------------------------------------
// pfa_dp
// Datapath: config registers, size table, fit search, write-back, result reg.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pfa_dp
   import pfa_pkg::*;
#(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
   parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pfa_cmd_type               cmd,
   output pfa_status_type                 status,
   input  wire logic [BLOCK_INDEX_W-1:0]  req_block_index,
   input  wire logic [REQUEST_SIZE_W-1:0] req_request_size,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_wr_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_granted,
   output logic [BLOCK_INDEX_W-1:0]       rsp_chosen_block
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int LD_W  = ((IDX_W > BLOCK_INDEX_W) ? IDX_W : BLOCK_INDEX_W) + 1;
   localparam int SZX_W = SIZE_BITS + REQUEST_SIZE_W;
   localparam int PX_W  = IDX_W + BLOCK_INDEX_W;

   // config
   logic [POLICY_W-1:0] policy_ff;
   logic [COUNT_W-1:0]  block_count_ff;

   // search state
   logic [SIZE_BITS-1:0] size_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     issue_ctr_ff;
   logic [IDX_W-1:0]     pos_ff;
   logic                 eval_vld_ff;
   logic [IDX_W-1:0]     eval_idx_ff;
   logic                 found_ff;
   logic [IDX_W-1:0]     pick_idx_ff;
   logic [SIZE_BITS-1:0] pick_val_ff;
   logic [IDX_W-1:0]     rover_ff;

   // result register
   logic                     rsp_valid_ff;
   logic                     rsp_granted_ff;
   logic [BLOCK_INDEX_W-1:0] rsp_chosen_ff;

   logic [CMP_W-1:0]     bc_ext;
   logic [CMP_W-1:0]     act_ext;
   logic [CNT_W-1:0]     act_cnt;
   logic [LD_W-1:0]      ld_ext;
   logic                 ld_ok;
   logic [SZX_W-1:0]     sz_ext;
   logic [SIZE_BITS-1:0] in_size;
   logic [IDX_W-1:0]     start_pos;
   logic [CNT_W-1:0]     pos_inc;
   logic [IDX_W-1:0]     pos_in;
   logic [CNT_W-1:0]     issue_inc;
   logic [SIZE_BITS-1:0] rd_data;
   logic                 adequate;
   logic                 take;
   logic [PX_W-1:0]      pick_ext;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [SIZE_BITS-1:0] wr_data;

   assign bc_ext  = CMP_W'(block_count_ff);
   assign act_ext = (bc_ext > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : bc_ext;
   assign act_cnt = act_ext[CNT_W-1:0];

   assign ld_ext  = LD_W'(req_block_index);
   assign ld_ok   = ld_ext < LD_W'(MAX_BLOCKS);
   assign sz_ext  = SZX_W'(req_request_size);
   assign in_size = sz_ext[SIZE_BITS-1:0];

   assign start_pos = (policy_ff == POLICY_NEXT && CNT_W'(rover_ff) < act_cnt) ?
                      rover_ff : '0;
   assign pos_inc   = CNT_W'(pos_ff) + CNT_W'(1);
   assign pos_in    = (pos_inc == cnt_ff) ? '0 : pos_inc[IDX_W-1:0];
   assign issue_inc = issue_ctr_ff + CNT_W'(1);

   assign adequate = rd_data >= size_ff;
   assign take     = eval_vld_ff && adequate &&
                     (!found_ff ||
                      (policy_ff == POLICY_BEST  && rd_data < pick_val_ff) ||
                      (policy_ff == POLICY_WORST && rd_data > pick_val_ff));

   assign pick_ext = PX_W'(pick_idx_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ld_ext[IDX_W-1:0];
      wr_data = in_size;
      if (cmd.load_start) begin
         wr_en = ld_ok;
      end else if (cmd.commit) begin
         wr_en   = found_ff;
         wr_addr = pick_idx_ff;
         wr_data = pick_val_ff - size_ff;
      end
   end

   pfa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (MAX_BLOCKS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff      <= POLICY_FIRST;
         block_count_ff <= BLOCK_COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIT_POLICY:  policy_ff      <= csr_wr_data[POLICY_W-1:0];
            CSR_BLOCK_COUNT: block_count_ff <= csr_wr_data[COUNT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         rover_ff    <= '0;
      end else begin
         eval_vld_ff <= cmd.scan_issue;
         if (cmd.req_start) begin
            found_ff <= 1'b0;
         end else if (take) begin
            found_ff <= 1'b1;
         end
         if (cmd.commit && found_ff && policy_ff == POLICY_NEXT) begin
            rover_ff <= pick_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_start) begin
         size_ff      <= in_size;
         cnt_ff       <= act_cnt;
         issue_ctr_ff <= '0;
         pos_ff       <= start_pos;
      end else if (cmd.scan_issue) begin
         issue_ctr_ff <= issue_inc;
         pos_ff       <= pos_in;
      end
      eval_idx_ff <= pos_ff;
      if (take) begin
         pick_idx_ff <= eval_idx_ff;
         pick_val_ff <= rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_granted_ff <= found_ff;
         rsp_chosen_ff  <= found_ff ? pick_ext[BLOCK_INDEX_W-1:0] : '0;
      end
   end

   assign status.count_zero = (act_cnt == '0);
   assign status.issue_last = (issue_inc == cnt_ff);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_block = rsp_chosen_ff;

   `ASSERT_IMPL(a_scan_bound, cmd.scan_issue, issue_ctr_ff < cnt_ff, "scan past block count")
   `ASSERT_IMPL(a_pick_range, cmd.commit && found_ff, CNT_W'(pick_idx_ff) < cnt_ff,
                "chosen block outside searched range")
   `ASSERT_NEXT(a_commit_rsp, cmd.commit, rsp_valid_ff, "commit did not load result")

endmodule

`default_nettype wire

// File: hw/rtl/partition_fit_allocator.sv
// ---------------------------------------------------------------------------
// partition_fit_allocator
// Partition table with first, best, worst and next fit allocation.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | op, block_index, request_size
//   rsp     | out       | rsp_valid/rsp_stall  | granted, chosen_block
//   csr     | in        | csr_wr_en            | csr_index, csr_wr_data
//
// A load writes the size table as it is accepted. An allocation request has
// an accept cycle, then one size-table entry read per cycle through the single
// RAM read port for min(block_count, MAX_BLOCKS) entries, then a drain state
// and a write-back/commit state. A block_count of zero skips scan and drain.
// Reset clears config, rover and control; partition sizes are undefined
// until loaded. A stalled result holds in the output register; a finished
// request waits in commit until that register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module partition_fit_allocator
   import pfa_pkg::*;
#(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
   parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_op,
   input  wire logic [BLOCK_INDEX_W-1:0]  req_block_index,
   input  wire logic [REQUEST_SIZE_W-1:0] req_request_size,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_granted,
   output logic [BLOCK_INDEX_W-1:0]       rsp_chosen_block,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_wr_data
);

   pfa_cmd_type    cmd;
   pfa_status_type status;

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pfa_dp #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_block_index  (req_block_index),
      .req_request_size (req_request_size),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block)
   );

endmodule

`default_nettype wire

// File: tb/sv/partition_fit_allocator_tb.sv
// ---------------------------------------------------------------------------
// partition_fit_allocator_tb
// Self-checking bench for the partition fit allocator. Loads and allocation
// requests go in through the req channel with random gaps. A local copy of
// the partition table, the roving pointer and the CSRs predicts each
// grant/deny result, and results are checked in order on the rsp channel,
// which stalls at random. Directed tests cover each fit policy, the
// block_count limits and the wrap of the roving pointer. Random phases then
// cycle through the policy and block_count settings.
// ---------------------------------------------------------------------------
`default_nettype none

module partition_fit_allocator_tb
   import pfa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PARTS   = DEF_MAX_BLOCKS;
   localparam int DRAIN_TICKS = 25;

   typedef struct packed {
      logic                     granted;
      logic [BLOCK_INDEX_W-1:0] block;
   } grant_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_op;
   logic [BLOCK_INDEX_W-1:0]  req_block_index;
   logic [REQUEST_SIZE_W-1:0] req_request_size;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_granted;
   logic [BLOCK_INDEX_W-1:0]  rsp_chosen_block;
   logic                      csr_wr_en;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]     csr_wr_data;

   // local copy of the partition table and allocator state
   logic [REQUEST_SIZE_W-1:0] free_size [NUM_PARTS];
   logic [BLOCK_INDEX_W-1:0]  next_ptr;
   logic [POLICY_W-1:0]       cur_policy;
   logic [COUNT_W-1:0]        cur_count;

   grant_type grant_queue [$];
   int     errors;
   int     req_gap_max;
   int     rsp_stall_max;
   int     stall_left;

   partition_fit_allocator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_block_index  (req_block_index),
      .req_request_size (req_request_size),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic void note_error(input string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
   endfunction

   // apply one accepted request to the table; an allocation also queues its expected result
   function automatic void place_request(input logic op, input logic [BLOCK_INDEX_W-1:0] idx,
                                         input logic [REQUEST_SIZE_W-1:0] size);
      int        cnt;
      int        pick;
      int        pos;
      grant_type res;
      if (op == OP_LOAD) begin
         free_size[idx] = size;
         return;
      end
      cnt  = (cur_count > NUM_PARTS) ? NUM_PARTS : cur_count;
      pick = -1;
      if (cur_policy == POLICY_NEXT) begin
         pos = (next_ptr < cnt) ? next_ptr : 0;
         for (int i = 0; i < cnt; i++) begin
            if (pick < 0) begin
               if (free_size[pos] >= size) pick = pos;
               else begin
                  pos++;
                  if (pos >= cnt) pos = 0;
               end
            end
         end
      end else begin
         for (int i = 0; i < cnt; i++) begin
            if (free_size[i] >= size) begin
               if (pick < 0 ||
                   (cur_policy == POLICY_BEST  && free_size[i] < free_size[pick]) ||
                   (cur_policy == POLICY_WORST && free_size[i] > free_size[pick]))
                  pick = i;
            end
         end
      end
      if (pick < 0) begin
         res.granted = 1'b0;
         res.block   = '0;
      end else begin
         free_size[pick] = free_size[pick] - size;
         if (cur_policy == POLICY_NEXT) next_ptr = pick[BLOCK_INDEX_W-1:0];
         res.granted = 1'b1;
         res.block   = pick[BLOCK_INDEX_W-1:0];
      end
      grant_queue.push_back(res);
   endfunction

   task automatic send_request(input logic op, input logic [BLOCK_INDEX_W-1:0] idx,
                               input logic [REQUEST_SIZE_W-1:0] size);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op           = op;
      req_block_index  = idx;
      req_request_size = size;
      req_valid        = 1'b1;
      do @(posedge clock); while (req_stall);
      place_request(op, idx, size);
   endtask

   // hold off until every result is back, then let a trailing load finish
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (grant_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_TICKS) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == CSR_FIT_POLICY) cur_policy = data[POLICY_W-1:0];
      else cur_count = data;
   endtask

   task automatic set_mode(input logic [POLICY_W-1:0] policy, input logic [COUNT_W-1:0] count);
      wait_idle();
      write_csr(CSR_FIT_POLICY, CSR_DATA_W'(policy));
      write_csr(CSR_BLOCK_COUNT, count);
   endtask

   function automatic logic [REQUEST_SIZE_W-1:0] rand_alloc_size();
      case ($urandom_range(0, 3))
         0: return REQUEST_SIZE_W'($urandom_range(0, 63));
         1: return REQUEST_SIZE_W'($urandom_range(0, 2047));
         2: return free_size[$urandom_range(0, NUM_PARTS - 1)];
         default: return REQUEST_SIZE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [REQUEST_SIZE_W-1:0] rand_load_size();
      case ($urandom_range(0, 3))
         0: return REQUEST_SIZE_W'($urandom_range(0, 255));
         1: return REQUEST_SIZE_W'($urandom_range(32768, 65535));
         2: return '1;
         default: return REQUEST_SIZE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // rsp side: checks each result and draws the next stall stretch
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         stall_left = $urandom_range(0, rsp_stall_max);
         if (grant_queue.size() == 0) begin
            note_error($sformatf("unexpected result granted=%0b block=%0d",
                                 rsp_granted, rsp_chosen_block));
         end else begin
            want = grant_queue.pop_front();
            if (rsp_granted !== want.granted || rsp_chosen_block !== want.block)
               note_error($sformatf({"result mismatch: expected granted=%0b block=%0d, ",
                                     "got granted=%0b block=%0d"},
                                    want.granted, want.block, rsp_granted,
                                    rsp_chosen_block));
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // reset config: first fit over 16 partitions; fill the whole table first
   task automatic test_reset_defaults();
      logic [REQUEST_SIZE_W-1:0] init;
      for (int i = 0; i < NUM_PARTS; i++) begin
         case (i)
            0: init = '0;
            1: init = 16'd500;
            2: init = 16'd120;
            3: init = '1;
            4: init = 16'd120;
            default: init = REQUEST_SIZE_W'(1000 + 7 * i);
         endcase
         send_request(OP_LOAD, BLOCK_INDEX_W'(i), init);
      end
      send_request(OP_ALLOC, 4'd9, 16'd100);
      send_request(OP_ALLOC, 4'd0, 16'd0);
      send_request(OP_ALLOC, 4'd15, 16'hFFFF);
      send_request(OP_ALLOC, 4'd3, 16'hFFFF);
   endtask

   task automatic test_fit_policies();
      set_mode(POLICY_BEST, 5'd16);
      send_request(OP_ALLOC, 4'd0, 16'd120);
      send_request(OP_ALLOC, 4'd0, 16'd1);
      set_mode(POLICY_WORST, 5'd16);
      send_request(OP_ALLOC, 4'd0, 16'd10);
      send_request(OP_ALLOC, 4'd0, 16'd10);
      set_mode(POLICY_NEXT, 5'd16);
      send_request(OP_ALLOC, 4'd0, 16'd400);
      send_request(OP_ALLOC, 4'd0, 16'd400);
      send_request(OP_ALLOC, 4'd0, 16'd60000);
   endtask

   task automatic test_block_count_limits();
      set_mode(POLICY_FIRST, 5'd1);
      send_request(OP_ALLOC, 4'd0, 16'd1);
      send_request(OP_ALLOC, 4'd0, 16'd0);
      set_mode(POLICY_FIRST, 5'd0);
      send_request(OP_ALLOC, 4'd0, 16'd0);
      set_mode(POLICY_NEXT, 5'd31);
      send_request(OP_ALLOC, 4'd0, 16'd5);
      set_mode(POLICY_FIRST, 5'd17);
      send_request(OP_ALLOC, 4'd0, 16'd50);
   endtask

   // park the rover high, then shrink block_count below it
   task automatic test_rover_wrap();
      set_mode(POLICY_NEXT, 5'd16);
      send_request(OP_LOAD, 4'd14, 16'hFFFF);
      send_request(OP_ALLOC, 4'd0, 16'd60000);
      set_mode(POLICY_NEXT, 5'd4);
      send_request(OP_ALLOC, 4'd0, 16'd0);
      send_request(OP_ALLOC, 4'd0, 16'hFFFF);
   endtask

   task automatic test_random_phases();
      logic [COUNT_W-1:0] counts [14];
      logic               op;
      counts = '{5'd16, 5'd1, 5'd2, 5'd5, 5'd8, 5'd16, 5'd0, 5'd31,
                 5'd17, 5'd3, 5'd12, 5'd16, 5'd15, 5'd16};
      for (int phase = 0; phase < 14; phase++) begin
         set_mode(POLICY_W'(phase % 4), counts[phase]);
         req_gap_max   = (phase % 3 == 0) ? 0 : 12;
         rsp_stall_max = (phase % 5 == 1) ? 0 : 12;
         for (int n = 0; n < 100; n++) begin
            op = ($urandom_range(0, 9) < 3) ? OP_LOAD : OP_ALLOC;
            send_request(op, BLOCK_INDEX_W'($urandom_range(0, NUM_PARTS - 1)),
                         (op == OP_LOAD) ? rand_load_size() : rand_alloc_size());
         end
      end
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = OP_LOAD;
      req_block_index  = '0;
      req_request_size = '0;
      rsp_stall        = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_FIT_POLICY;
      csr_wr_data      = '0;
      errors           = 0;
      stall_left       = 0;
      req_gap_max      = 12;
      rsp_stall_max    = 12;
      next_ptr         = '0;
      cur_policy       = POLICY_FIRST;
      cur_count        = BLOCK_COUNT_RESET;
      foreach (free_size[i]) free_size[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_fit_policies();
      test_block_count_limits();
      test_rover_wrap();
      test_random_phases();

      wait_idle();
      if (grant_queue.size() != 0)
         note_error($sformatf("%0d results never arrived", grant_queue.size()));
      if (errors == 0) begin
         $display("[partition_fit_allocator] OK");
      end else begin
         $display("[partition_fit_allocator] ERROR");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("[partition_fit_allocator] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_ram.sv
hw/rtl/pfa_ctrl.sv
hw/rtl/pfa_dp.sv
hw/rtl/partition_fit_allocator.sv
tb/sv/partition_fit_allocator_tb.sv
